@@ src/pes_hdr_pkg.sv @@
// Package: PES header parser types, result codes and field-extraction helpers.
`timescale 1ns / 1ps

package pes_hdr_pkg;

	localparam int unsigned DATA_W     = 8;
	localparam int unsigned TS_W       = 33;
	localparam int unsigned ESCR_W     = 42;
	localparam int unsigned ESCR_EXT_W = 9;
	localparam int unsigned RATE_W     = 22;
	localparam int unsigned LEN_W      = 16;
	localparam int unsigned IDX_W      = 8;
	localparam int unsigned REQ_W      = 5;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned TDATA_W    = 200;

	localparam logic [IDX_W-1:0] IDX_SID      = 8'd3;
	localparam logic [IDX_W-1:0] IDX_LEN_HI   = 8'd4;
	localparam logic [IDX_W-1:0] IDX_LEN_LO   = 8'd5;
	localparam logic [IDX_W-1:0] IDX_FLAGS_HI = 8'd6;
	localparam logic [IDX_W-1:0] IDX_FLAGS_LO = 8'd7;
	localparam logic [IDX_W-1:0] IDX_HDR_LEN  = 8'd8;

	localparam logic [IDX_W-1:0] TS_BYTES     = 8'd5;
	localparam logic [LEN_W-1:0] MIN_OPT_LEN  = 16'd3;

	typedef enum logic [KIND_W-1:0] {
		KIND_SUMMARY,
		KIND_PAYLOAD,
		KIND_BAD_START,
		KIND_LEN_ERR
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [7:0]            pes_id;
		logic [LEN_W-1:0]      packet_length;
		logic [LEN_W-1:0]      flag_bits;
		logic [TS_W-1:0]       pts_value;
		logic [TS_W-1:0]       dts_value;
		logic [TS_W-1:0]       escr_ref;
		logic [ESCR_EXT_W-1:0] escr_extension;
		logic [RATE_W-1:0]     es_rate;
		logic [LEN_W-1:0]      payload_size;
		logic [DATA_W-1:0]     payload_byte;
		logic                  last;
	} result_t;

	function automatic logic lacks_opt_header(logic [7:0] sid);
		return sid == 8'hBC || sid == 8'hBE || sid == 8'hBF || sid == 8'hF0 ||
		       sid == 8'hF1 || sid == 8'hF2 || sid == 8'hF8 || sid == 8'hFF;
	endfunction

	function automatic logic [REQ_W-1:0] ts_len(logic [LEN_W-1:0] flags);
		logic [REQ_W-1:0] n;
		unique case (flags[7:6])
			2'b10:   n = 5'd5;
			2'b11:   n = 5'd10;
			default: n = 5'd0;
		endcase
		return n;
	endfunction

	function automatic logic [REQ_W-1:0] required_bytes(logic [LEN_W-1:0] f);
		return ts_len(f) + (f[5] ? 5'd6 : 5'd0) + (f[4] ? 5'd3 : 5'd0) +
		       REQ_W'(f[3]) + REQ_W'(f[2]) + REQ_W'({f[1], 1'b0}) + REQ_W'(f[0]);
	endfunction

	function automatic logic [TS_W-1:0] ts_shift(logic [TS_W-1:0] acc,
	                                              logic [IDX_W-1:0] k,
	                                              logic [DATA_W-1:0] b);
		logic [TS_W-1:0] r;
		unique case (k)
			8'd0:       r = {30'b0, b[3:1]};
			8'd1, 8'd3: r = {acc[24:0], b};
			default:    r = {acc[25:0], b[7:1]};
		endcase
		return r;
	endfunction

	function automatic logic [ESCR_W-1:0] escr_shift(logic [ESCR_W-1:0] acc,
	                                                  logic [IDX_W-1:0] k,
	                                                  logic [DATA_W-1:0] b);
		logic [ESCR_W-1:0] r;
		unique case (k)
			8'd0:       r = {37'b0, b[5:3], b[1:0]};
			8'd1, 8'd3: r = {acc[33:0], b};
			8'd2, 8'd4: r = {acc[34:0], b[7:3], b[1:0]};
			default:    r = {acc[34:0], b[7:1]};
		endcase
		return r;
	endfunction

	function automatic logic [RATE_W-1:0] rate_shift(logic [RATE_W-1:0] acc,
	                                                  logic [IDX_W-1:0] k,
	                                                  logic [DATA_W-1:0] b);
		logic [RATE_W-1:0] r;
		unique case (k)
			8'd0:    r = {15'b0, b[6:0]};
			8'd1:    r = {acc[13:0], b};
			default: r = {acc[14:0], b[7:1]};
		endcase
		return r;
	endfunction

endpackage

@@ src/pes_header_parser.sv @@
// MPEG-2 PES packet header parser: prefix hunt, header capture, payload pass-through.
// One stream byte is taken per cycle while the slave side does not stall, and every
// byte may follow the previous one in the next cycle. A byte passes an input register
// and then the parse logic, which updates the parse state and loads the result
// register; the master side presents each result from that register. Each byte
// gives at most one result: a header summary (time stamps, ESCR, ES_rate, payload
// size), a payload byte, a bad start code or a length error. tlast on the master side
// marks the final result of a packet. The slave side stalls only while the result
// register holds a result that is not yet taken and the input register is full.
`timescale 1ns / 1ps

module pes_header_parser
	import pes_hdr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] data_byte
	input  logic               s_tlast,   // end_of_data
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // pes_id, packet_length, flag_bits, pts_value,
	                                      // dts_value, escr_ref, escr_extension, es_rate,
	                                      // payload_size, payload_byte, zero fill
	output logic [KIND_W-1:0]  m_tuser,   // kind
	output logic               m_tlast    // last
);

	typedef enum logic [1:0] {
		PH_SEARCH,
		PH_FIXED,
		PH_OPT,
		PH_PAYLOAD
	} phase_t;

	logic              valid_s1;
	logic [DATA_W-1:0] byte_s1;
	logic              eod_s1;
	logic              out_free;
	logic              advance;

	phase_t            phase_q, phase_n;
	logic [IDX_W-1:0]  idx_q, idx_n;
	logic [7:0]        hdl_q, hdl_n;
	logic [7:0]        sid_q, sid_n;
	logic [LEN_W-1:0]  len_q, len_n;
	logic [LEN_W-1:0]  flags_q, flags_n;
	logic [TS_W-1:0]   pts_q, pts_n;
	logic [TS_W-1:0]   dts_q, dts_n;
	logic [ESCR_W-1:0] escr_q, escr_n;
	logic [RATE_W-1:0] rate_q, rate_n;
	logic [LEN_W-1:0]  rem_q, rem_n;

	logic              emit;
	result_t           res_d, res_q;
	logic              res_valid_q;

	assign out_free = !res_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_comb begin
		logic [1:0]        sidx;
		logic              bad;
		logic              do_sum;
		logic              do_err;
		logic              do_clear;
		logic              full;
		logic              bounded;
		logic              sum_last;
		logic [IDX_W-1:0]  p;
		logic [IDX_W-1:0]  pe;
		logic [IDX_W-1:0]  per;
		logic [IDX_W:0]    o_inc;
		logic [LEN_W:0]    need;
		logic [LEN_W-1:0]  rem_dec;
		kind_t             kind;
		logic              last;
		logic [DATA_W-1:0] pbyte;

		phase_n  = phase_q;
		idx_n    = idx_q;
		hdl_n    = hdl_q;
		sid_n    = sid_q;
		len_n    = len_q;
		flags_n  = flags_q;
		pts_n    = pts_q;
		dts_n    = dts_q;
		escr_n   = escr_q;
		rate_n   = rate_q;
		rem_n    = rem_q;
		emit     = 1'b0;
		do_sum   = 1'b0;
		do_err   = 1'b0;
		do_clear = 1'b0;
		bad      = 1'b0;
		full     = 1'b0;
		kind     = KIND_SUMMARY;
		last     = 1'b0;
		pbyte    = '0;
		sidx     = (idx_q <= 8'd2) ? idx_q[1:0] : 2'd0;
		p        = IDX_W'(ts_len(flags_q));
		pe       = p + (flags_q[5] ? 8'd6 : 8'd0);
		per      = pe + (flags_q[4] ? 8'd3 : 8'd0);
		o_inc    = {1'b0, idx_q} + 9'd1;
		need     = 17'(MIN_OPT_LEN) + 17'(byte_s1);
		rem_dec  = (rem_q != '0) ? rem_q - 16'd1 : rem_q;
		bounded  = 1'b0;
		sum_last = 1'b0;

		unique case (phase_q)
			PH_SEARCH: begin
				if (sidx < 2'd2) begin
					if (byte_s1 == '0) begin
						sidx = sidx + 2'd1;
					end else begin
						bad = 1'b1;
					end
					idx_n = eod_s1 ? '0 : IDX_W'(sidx);
				end else if (byte_s1 == 8'd1) begin
					do_clear = 1'b1;
					phase_n  = PH_FIXED;
					idx_n    = IDX_SID;
					do_err   = eod_s1;
				end else if (byte_s1 != '0) begin
					bad = 1'b1;
				end else begin
					idx_n = eod_s1 ? '0 : IDX_W'(sidx);
				end
				if (bad) begin
					do_clear = 1'b1;
					idx_n    = '0;
					emit     = 1'b1;
					kind     = KIND_BAD_START;
					last     = 1'b1;
				end
			end
			PH_FIXED: begin
				idx_n = idx_q + 8'd1;
				unique case (idx_q)
					IDX_SID: begin
						sid_n  = byte_s1;
						do_err = eod_s1;
					end
					IDX_LEN_HI: begin
						len_n  = {byte_s1, 8'h00};
						do_err = eod_s1;
					end
					IDX_LEN_LO: begin
						len_n = {len_q[15:8], byte_s1};
						if (lacks_opt_header(sid_q)) begin
							rem_n  = len_n;
							do_sum = 1'b1;
						end else begin
							do_err = (len_n != '0 && len_n < MIN_OPT_LEN) || eod_s1;
						end
					end
					IDX_FLAGS_HI: begin
						flags_n = {byte_s1, 8'h00};
						do_err  = eod_s1;
					end
					IDX_FLAGS_LO: begin
						flags_n = {flags_q[15:8], byte_s1};
						do_err  = eod_s1;
					end
					IDX_HDR_LEN: begin
						hdl_n = byte_s1;
						rem_n = (len_q != '0) ? len_q - MIN_OPT_LEN - LEN_W'(byte_s1) : '0;
						if (8'(required_bytes(flags_q)) > byte_s1 ||
						    (len_q != '0 && {1'b0, len_q} < need)) begin
							do_err = 1'b1;
						end else if (byte_s1 == '0) begin
							do_sum = 1'b1;
						end else if (eod_s1) begin
							do_err = 1'b1;
						end else begin
							phase_n = PH_OPT;
							idx_n   = '0;
						end
					end
					default: begin
						phase_n = PH_SEARCH;
						idx_n   = '0;
					end
				endcase
			end
			PH_OPT: begin
				if (idx_q < p) begin
					if (idx_q < TS_BYTES) begin
						pts_n = ts_shift(pts_q, idx_q, byte_s1);
					end else begin
						dts_n = ts_shift(dts_q, idx_q - TS_BYTES, byte_s1);
					end
				end else if (idx_q < pe) begin
					escr_n = escr_shift(escr_q, idx_q - p, byte_s1);
				end else if (idx_q < per) begin
					rate_n = rate_shift(rate_q, idx_q - pe, byte_s1);
				end
				if (o_inc >= {1'b0, hdl_q}) begin
					do_sum = 1'b1;
				end else if (eod_s1) begin
					do_err = 1'b1;
				end else begin
					idx_n = o_inc[IDX_W-1:0];
				end
			end
			PH_PAYLOAD: begin
				if (len_q != '0) begin
					rem_n = rem_dec;
					last  = rem_dec == '0 || eod_s1;
				end else begin
					last  = eod_s1;
				end
				emit  = 1'b1;
				kind  = KIND_PAYLOAD;
				pbyte = byte_s1;
				if (last) begin
					phase_n = PH_SEARCH;
					idx_n   = '0;
				end
			end
			default: begin
				phase_n = PH_SEARCH;
				idx_n   = '0;
			end
		endcase

		if (do_clear) begin
			hdl_n   = '0;
			sid_n   = '0;
			len_n   = '0;
			flags_n = '0;
			pts_n   = '0;
			dts_n   = '0;
			escr_n  = '0;
			rate_n  = '0;
			rem_n   = '0;
		end

		if (do_sum) begin
			bounded  = len_n != '0;
			sum_last = (bounded && rem_n == '0) || eod_s1;
			emit     = 1'b1;
			kind     = KIND_SUMMARY;
			full     = 1'b1;
			last     = sum_last;
			phase_n  = sum_last ? PH_SEARCH : PH_PAYLOAD;
			idx_n    = '0;
		end else if (do_err) begin
			emit    = 1'b1;
			kind    = KIND_LEN_ERR;
			last    = 1'b1;
			phase_n = PH_SEARCH;
			idx_n   = '0;
		end

		res_d.kind           = kind;
		res_d.pes_id         = sid_n;
		res_d.packet_length  = len_n;
		res_d.flag_bits      = flags_n;
		res_d.pts_value      = full ? pts_n : '0;
		res_d.dts_value      = full ? dts_n : '0;
		res_d.escr_ref       = full ? escr_n[ESCR_W-1:ESCR_EXT_W] : '0;
		res_d.escr_extension = full ? escr_n[ESCR_EXT_W-1:0] : '0;
		res_d.es_rate        = full ? rate_n : '0;
		res_d.payload_size   = (full && bounded) ? rem_n : '0;
		res_d.payload_byte   = pbyte;
		res_d.last           = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			phase_q     <= PH_SEARCH;
			idx_q       <= '0;
			hdl_q       <= '0;
			sid_q       <= '0;
			len_q       <= '0;
			flags_q     <= '0;
			pts_q       <= '0;
			dts_q       <= '0;
			escr_q      <= '0;
			rate_q      <= '0;
			rem_q       <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_free) begin
				res_valid_q <= advance && emit;
			end
			if (advance) begin
				phase_q <= phase_n;
				idx_q   <= idx_n;
				hdl_q   <= hdl_n;
				sid_q   <= sid_n;
				len_q   <= len_n;
				flags_q <= flags_n;
				pts_q   <= pts_n;
				dts_q   <= dts_n;
				escr_q  <= escr_n;
				rate_q  <= rate_n;
				rem_q   <= rem_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eod_s1  <= s_tlast;
		end
		if (advance && emit) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tuser  = res_q.kind;
	assign m_tlast  = res_q.last;
	assign m_tdata  = {6'b0, res_q.payload_byte, res_q.payload_size, res_q.es_rate,
	                   res_q.escr_extension, res_q.escr_ref, res_q.dts_value,
	                   res_q.pts_value, res_q.flag_bits, res_q.packet_length,
	                   res_q.pes_id};

	a_search_index: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SEARCH |-> idx_q <= 8'd2)
		else $error("search index out of range");

	a_fixed_index: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FIXED |-> idx_q >= IDX_SID && idx_q <= IDX_HDR_LEN)
		else $error("fixed header index out of range");

	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD && len_q != '0) |-> rem_q != '0)
		else $error("payload phase with nothing left");

	a_bad_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && res_d.kind == KIND_BAD_START) |->
		(res_d.pes_id == '0 && res_d.packet_length == '0 && res_d.last))
		else $error("bad start code result carries stale fields");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1) && $stable(eod_s1)))
		else $error("input register lost a byte");

endmodule

@@ tb/sv/tb_pes_header_parser.sv @@
// Testbench for pes_header_parser: random and directed PES streams checked against a byte-level parser model.
`timescale 1ns / 1ps

module tb_pes_header_parser;
	import pes_hdr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BYTES = 100;

	localparam int SID_LSB  = 0;
	localparam int LEN_LSB  = 8;
	localparam int FLG_LSB  = 24;
	localparam int PTS_LSB  = 40;
	localparam int DTS_LSB  = 73;
	localparam int EB_LSB   = 106;
	localparam int EX_LSB   = 139;
	localparam int RATE_LSB = 148;
	localparam int PSZ_LSB  = 170;
	localparam int PB_LSB   = 186;
	localparam int FILL_LSB = 194;

	typedef enum logic [1:0] {HUNT, FIXED_HDR, OPT_HDR, PAYLOAD} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eod;
	} stream_byte_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = 8'h00;
	logic               s_tlast = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic [KIND_W-1:0]  m_tuser;
	logic               m_tlast;

	pes_header_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	stream_byte_t pending_bytes[$];
	stream_byte_t next_byte;
	result_t      expected_results[$];
	result_t      want;
	logic [7:0]   bare_ids [8] = '{8'hBC, 8'hBE, 8'hBF, 8'hF0, 8'hF1, 8'hF2, 8'hF8, 8'hFF};

	int  gap_pct = 0;
	int  stall_pct = 0;
	int  mismatches = 0;
	int  bytes_queued = 0;
	int  results_checked = 0;
	int  cycle_count = 0;
	int  kind_count [4] = '{0, 0, 0, 0};
	bit  in_fire = 1'b0;

	// parser model state
	phase_t      phase = HUNT;
	logic [15:0] idx = '0;
	logic [7:0]  hdr_len = '0;
	logic [7:0]  sid = '0;
	logic [15:0] plen = '0;
	logic [15:0] flags = '0;
	logic [15:0] remaining = '0;
	logic [32:0] pts = '0;
	logic [32:0] dts = '0;
	logic [41:0] escr = '0;
	logic [21:0] rate = '0;

	function automatic bit no_opt_header(logic [7:0] id);
		foreach (bare_ids[i])
			if (bare_ids[i] == id) return 1'b1;
		return 1'b0;
	endfunction

	function automatic int unsigned stamp_bytes(logic [15:0] f);
		case (f[7:6])
			2'b10:   return 5;
			2'b11:   return 10;
			default: return 0;
		endcase
	endfunction

	function automatic int unsigned needed_opt_bytes(logic [15:0] f);
		return stamp_bytes(f) + (f[5] ? 6 : 0) + (f[4] ? 3 : 0) + int'(f[3]) + int'(f[2]) +
		       2 * int'(f[1]) + int'(f[0]);
	endfunction

	function automatic logic [32:0] next_stamp(logic [32:0] acc, int unsigned k, logic [7:0] b);
		case (k)
			0:       return 33'(b[3:1]);
			1, 3:    return (acc << 8) | b;
			default: return (acc << 7) | b[7:1];
		endcase
	endfunction

	task automatic forget_packet();
		hdr_len = '0;
		sid = '0;
		plen = '0;
		flags = '0;
		pts = '0;
		dts = '0;
		escr = '0;
		rate = '0;
		remaining = '0;
	endtask

	task automatic queue_result(kind_t k, bit full, logic [15:0] psize, logic [7:0] pbyte,
	                            bit last);
		result_t r;
		r.kind = k;
		r.pes_id = sid;
		r.packet_length = plen;
		r.flag_bits = flags;
		r.pts_value = full ? pts : '0;
		r.dts_value = full ? dts : '0;
		r.escr_ref = full ? escr[41:9] : '0;
		r.escr_extension = full ? escr[8:0] : '0;
		r.es_rate = full ? rate : '0;
		r.payload_size = psize;
		r.payload_byte = pbyte;
		r.last = last;
		expected_results = {expected_results, r};
	endtask

	task automatic flag_length_error();
		queue_result(KIND_LEN_ERR, 1'b0, '0, '0, 1'b1);
		phase = HUNT;
		idx = '0;
	endtask

	task automatic finish_header(bit eod);
		bit bounded;
		bit last;
		bounded = plen != 0;
		last = (bounded && remaining == 0) || eod;
		queue_result(KIND_SUMMARY, 1'b1, bounded ? remaining : 16'd0, '0, last);
		phase = last ? HUNT : PAYLOAD;
		idx = '0;
	endtask

	task automatic parse_stream_byte(logic [7:0] b, bit eod);
		logic [15:0] pos;
		bit          bad;
		bit          last;
		int unsigned o, p, e, r, k;
		case (phase)
			HUNT: begin
				pos = (idx <= 2) ? idx : 16'd0;
				bad = 1'b0;
				if (pos < 2) begin
					if (b == 8'h00) pos++;
					else bad = 1'b1;
				end else if (b == 8'h01) begin
					forget_packet();
					phase = FIXED_HDR;
					idx = 16'd3;
					if (eod) flag_length_error();
					return;
				end else if (b != 8'h00) begin
					bad = 1'b1;
				end
				if (bad) begin
					forget_packet();
					idx = '0;
					queue_result(KIND_BAD_START, 1'b0, '0, '0, 1'b1);
				end else begin
					idx = eod ? 16'd0 : pos;
				end
			end
			FIXED_HDR: begin
				case (idx)
					16'd3: sid = b;
					16'd4: plen = {b, 8'h00};
					16'd5: begin
						plen[7:0] = b;
						if (no_opt_header(sid)) begin
							remaining = plen;
							finish_header(eod);
							return;
						end
						if (plen != 0 && plen < 3) begin
							flag_length_error();
							return;
						end
					end
					16'd6: flags = {b, 8'h00};
					16'd7: flags[7:0] = b;
					16'd8: begin
						hdr_len = b;
						if (needed_opt_bytes(flags) > b || (plen != 0 && plen < 3 + b)) begin
							flag_length_error();
							return;
						end
						remaining = (plen != 0) ? 16'(plen - 3 - b) : 16'd0;
						if (b == 0) finish_header(eod);
						else if (eod) flag_length_error();
						else begin
							phase = OPT_HDR;
							idx = '0;
						end
						return;
					end
					default: begin
						phase = HUNT;
						idx = '0;
						return;
					end
				endcase
				if (eod) flag_length_error();
				else idx++;
			end
			OPT_HDR: begin
				o = idx[7:0];
				p = stamp_bytes(flags);
				e = flags[5] ? 6 : 0;
				r = flags[4] ? 3 : 0;
				if (o < p) begin
					if (o < 5) pts = next_stamp(pts, o, b);
					else dts = next_stamp(dts, o - 5, b);
				end else if (o < p + e) begin
					k = o - p;
					case (k)
						0:       escr = 42'({b[5:3], b[1:0]});
						1, 3:    escr = (escr << 8) | b;
						2, 4:    escr = (escr << 7) | {b[7:3], b[1:0]};
						default: escr = (escr << 7) | b[7:1];
					endcase
				end else if (o < p + e + r) begin
					k = o - p - e;
					case (k)
						0:       rate = 22'(b[6:0]);
						1:       rate = (rate << 8) | b;
						default: rate = (rate << 7) | b[7:1];
					endcase
				end
				if (o + 1 >= hdr_len) finish_header(eod);
				else if (eod) flag_length_error();
				else idx = 16'(o + 1);
			end
			PAYLOAD: begin
				if (plen != 0) begin
					if (remaining > 0) remaining--;
					last = remaining == 0 || eod;
				end else begin
					last = eod;
				end
				queue_result(KIND_PAYLOAD, 1'b0, '0, b, last);
				if (last) begin
					phase = HUNT;
					idx = '0;
				end
			end
		endcase
	endtask

	task automatic put_byte(logic [7:0] b, bit eod);
		stream_byte_t sb;
		sb.data = b;
		sb.eod = eod;
		pending_bytes = {pending_bytes, sb};
		bytes_queued++;
	endtask

	// 0 < cut < packet size truncates it, end_of_data on the last byte; fill < 0 means random content
	task automatic put_packet(logic [7:0] id, logic [15:0] len, logic [15:0] f, logic [7:0] hl,
	                          int n_pay, int cut, int fill);
		logic [7:0] pk[$];
		int         total;
		pk = {pk, 8'h00};
		pk = {pk, 8'h00};
		pk = {pk, 8'h01};
		pk = {pk, id};
		pk = {pk, len[15:8]};
		pk = {pk, len[7:0]};
		if (!no_opt_header(id)) begin
			pk = {pk, f[15:8]};
			pk = {pk, f[7:0]};
			pk = {pk, hl};
			for (int i = 0; i < hl; i++) pk = {pk, (fill < 0) ? 8'($urandom) : 8'(fill)};
		end
		for (int i = 0; i < n_pay; i++) pk = {pk, (fill < 0) ? 8'($urandom) : 8'(fill)};
		total = pk.size();
		if (cut > 0 && cut < total) total = cut;
		for (int i = 0; i < total; i++)
			put_byte(pk[i], (i == total - 1) && (total < pk.size() || len == 0));
	endtask

	task automatic put_directed();
		put_byte(8'hFF, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h02, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h00, 1'b1);
		put_byte(8'h01, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h01, 1'b1);
		put_packet(8'hBC, 16'd1, 16'h0000, 8'd0, 1, 0, 8'hAA);
		put_packet(8'hFF, 16'd0, 16'h0000, 8'd0, 2, 0, -1);
		put_byte(8'h00, 1'b0);
		put_packet(8'hE0, 16'd0, 16'h80C0, 8'd10, 2, 0, 8'hFF);
		put_packet(8'hC0, 16'd13, 16'h8430, 8'd9, 1, 0, 8'hFF);
		put_packet(8'hBD, 16'd11, 16'h800F, 8'd7, 1, 0, 8'h00);
		put_packet(8'hE0, 16'd3, 16'h8040, 8'd0, 0, 0, 8'h00);
		put_packet(8'hC0, 16'd2, 16'h0000, 8'd0, 0, 0, 8'h00);
		put_packet(8'hC0, 16'h0010, 16'h8080, 8'd2, 0, 0, 8'h00);
		put_packet(8'hC0, 16'd4, 16'h8000, 8'd2, 0, 0, 8'h00);
		put_packet(8'hE0, 16'd0, 16'h8000, 8'd0, 0, 5, 8'h00);
		put_packet(8'hE0, 16'hFFFF, 16'h0000, 8'd0, 3, 11, 8'h5A);
		put_packet(8'hE0, 16'd40, 16'h80C0, 8'd10, 4, 12, -1);
	endtask

	task automatic put_random_traffic();
		int          r, n_pay, cut, hl;
		logic [7:0]  id;
		logic [15:0] f, len;
		r = $urandom_range(99);
		if (r < 12) begin
			repeat ($urandom_range(1, 6)) put_byte(8'($urandom), $urandom_range(7) == 0);
		end else if (r < 22) begin
			put_byte(8'h00, 1'b0);
			if ($urandom_range(1)) begin
				put_byte(8'h00, 1'b0);
				put_byte(8'($urandom_range(2, 255)), 1'b0);
			end else begin
				put_byte(8'($urandom_range(1, 255)), 1'b0);
			end
		end else begin
			if ($urandom_range(4) == 0) put_byte(8'h00, 1'b0);
			case ($urandom_range(9))
				0, 1:    id = bare_ids[$urandom_range(7)];
				2:       id = 8'($urandom);
				3, 4:    id = {3'b110, 5'($urandom)};
				default: id = {4'hE, 4'($urandom)};
			endcase
			f = {2'b10, 6'($urandom), 8'($urandom)};
			if ($urandom_range(4) == 0) f = 16'($urandom);
			hl = needed_opt_bytes(f) + $urandom_range(0, 3);
			if ($urandom_range(9) == 0 && needed_opt_bytes(f) > 0) hl = needed_opt_bytes(f) - 1;
			n_pay = $urandom_range(0, 6);
			len = no_opt_header(id) ? 16'(n_pay) : 16'(3 + hl + n_pay);
			case ($urandom_range(9))
				0:       len = 16'd0;
				1:       len = 16'($urandom_range(0, len));
				default: len = len;
			endcase
			cut = ($urandom_range(9) == 0) ? $urandom_range(1, 30) : 0;
			put_packet(id, len, f, 8'(hl), n_pay, cut, -1);
		end
	endtask

	task automatic compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
		if (exp_val !== act_val) begin
			mismatches++;
			$display("%0t ns: %s expected %0h, got %0h", $time, name, exp_val, act_val);
		end
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			m_tready <= $urandom_range(99) >= stall_pct;
			if (!s_tvalid || in_fire) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= gap_pct) begin
					next_byte = pending_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_byte.data;
					s_tlast <= next_byte.eod;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			in_fire = 1'b0;
		end else if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			         expected_results.size());
			$display("end of test: mismatches");
			$finish;
		end else begin
			cycle_count++;
			in_fire = s_tvalid && s_tready;
			if (in_fire) parse_stream_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t ns: result expected none, got kind %0d tdata %0h", $time,
					         m_tuser, m_tdata);
				end else begin
					want = expected_results.pop_front();
					compare_field("kind", want.kind, m_tuser);
					compare_field("pes_id", want.pes_id, m_tdata[SID_LSB +: 8]);
					compare_field("packet_length", want.packet_length, m_tdata[LEN_LSB +: LEN_W]);
					compare_field("flag_bits", want.flag_bits, m_tdata[FLG_LSB +: LEN_W]);
					compare_field("pts_value", want.pts_value, m_tdata[PTS_LSB +: TS_W]);
					compare_field("dts_value", want.dts_value, m_tdata[DTS_LSB +: TS_W]);
					compare_field("escr_ref", want.escr_ref, m_tdata[EB_LSB +: TS_W]);
					compare_field("escr_extension", want.escr_extension,
					              m_tdata[EX_LSB +: ESCR_EXT_W]);
					compare_field("es_rate", want.es_rate, m_tdata[RATE_LSB +: RATE_W]);
					compare_field("payload_size", want.payload_size, m_tdata[PSZ_LSB +: LEN_W]);
					compare_field("payload_byte", want.payload_byte, m_tdata[PB_LSB +: DATA_W]);
					compare_field("tdata fill", '0, m_tdata[TDATA_W-1:FILL_LSB]);
					compare_field("last", want.last, m_tlast);
					results_checked++;
					kind_count[m_tuser]++;
				end
			end
		end
	end

	initial begin
		int start;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					gap_pct = 16;
					stall_pct = 85;
					put_directed();
				end
				1: begin
					gap_pct = 85;
					stall_pct = 16;
				end
				default: begin
					gap_pct = 0;
					stall_pct = 0;
				end
			endcase
			start = bytes_queued;
			while (bytes_queued - start < RANDOM_BYTES) put_random_traffic();
			while (pending_bytes.size() != 0) @(posedge clk);
		end
		while (s_tvalid || expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("sent %0d stream bytes under three sender/receiver idle mixes", bytes_queued);
		$display("checked %0d results: %0d headers, %0d payload, %0d bad start, %0d length errors",
		         results_checked, kind_count[KIND_SUMMARY], kind_count[KIND_PAYLOAD],
		         kind_count[KIND_BAD_START], kind_count[KIND_LEN_ERR]);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
